[rtl/assert_macros.svh]
// Assertion macros shared by the RPM estimator modules.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Condition holds at every edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

`endif

[rtl/wre_pkg.sv]
// Shared types and constants for the windowed RPM estimator.
// No dependencies; imported by the controller, datapath, divider and top level.
`default_nettype none

package wre_pkg;

	localparam int TIME_W     = 32;
	localparam int COUNT_W    = 15;
	localparam int RATE_W     = 16;
	localparam int SCALE_W    = 24;
	localparam int MOD_W      = 15;
	localparam int PROD_W     = SCALE_W + COUNT_W;
	localparam int REM_W      = 32;
	localparam int DIFF_W     = COUNT_W + 1;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 24;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE      = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNTER_MODULUS = 8'd1;

	localparam logic [SCALE_W-1:0] SCALE_RESET   = 24'd15000000;
	localparam logic [MOD_W-1:0]   MODULUS_RESET = 15'd32767;
	localparam logic [RATE_W-1:0]  RATE_MAX      = 16'hFFFF;

	typedef struct packed {
		logic [TIME_W-1:0]  time_us;
		logic [COUNT_W-1:0] pulse_count;
		logic [RATE_W-1:0]  rate;
	} snap_t;

	typedef enum logic [1:0] {
		DIV_MOD,
		DIV_INST,
		DIV_AVG
	} div_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FETCH,
		S_MOD_GO,
		S_MOD_WAIT,
		S_PULSE,
		S_MUL,
		S_INST_GO,
		S_INST_WAIT,
		S_SUM,
		S_AVG_GO,
		S_AVG_WAIT,
		S_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic     in_load;
		logic     fetch;
		logic     div_start;
		div_sel_t div_sel;
		logic     pulse_calc;
		logic     mul;
		logic     inst_direct;
		logic     inst_take;
		logic     sum_upd;
		logic     out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
		logic inst_direct;
		logic out_free;
	} ctrl_sts_t;

endpackage

`default_nettype wire

[rtl/wre_div.sv]
// Shared restoring divider: one quotient bit per cycle, remainder kept.
// Depends on wre_pkg for the remainder width and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module wre_div #(
	parameter int NUM_W = 20,
	localparam int STEP_W = $clog2(NUM_W + 1)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [wre_pkg::REM_W-1:0] rem_init,
	input  wire logic [NUM_W-1:0]          num,
	input  wire logic [wre_pkg::REM_W-1:0] den,
	input  wire logic [STEP_W-1:0]         steps,
	output logic                           busy,
	output logic                           done,
	output logic [NUM_W-1:0]               quo,
	output logic [wre_pkg::REM_W-1:0]      rem
);
	import wre_pkg::*;

	logic [REM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  num_q;
	logic [REM_W-1:0]  den_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [REM_W:0]    trial;
	logic [REM_W:0]    diff;
	logic              ge;

	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == STEP_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			num_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = num_q;
	assign rem  = rem_q;

	`ASSERT_IMPLIES(a_no_restart, clk, arst_n, start, !busy_q, "divider started while busy")
	`ASSERT_NEXT(a_done_ends, clk, arst_n, done_q, !busy_q && !done_q, "divider done not single")

endmodule

`default_nettype wire

[rtl/wre_ctrl.sv]
// Sequencer for one sample: fetch, modulo, multiply, divide, sum, average.
// Depends on wre_pkg for the state, command and status types.
`default_nettype none
`include "assert_macros.svh"

module wre_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire wre_pkg::ctrl_sts_t    sts,
	output wre_pkg::ctrl_cmd_t         cmd
);
	import wre_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:      if (in_valid) state_d = S_FETCH;
			S_FETCH:     state_d = S_MOD_GO;
			S_MOD_GO:    state_d = S_MOD_WAIT;
			S_MOD_WAIT:  if (sts.div_done) state_d = S_PULSE;
			S_PULSE:     state_d = S_MUL;
			S_MUL:       state_d = S_INST_GO;
			S_INST_GO:   state_d = sts.inst_direct ? S_SUM : S_INST_WAIT;
			S_INST_WAIT: if (sts.div_done) state_d = S_SUM;
			S_SUM:       state_d = S_AVG_GO;
			S_AVG_GO:    state_d = S_AVG_WAIT;
			S_AVG_WAIT:  if (sts.div_done) state_d = S_OUT;
			S_OUT:       if (sts.out_free) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.in_load = in_valid;
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
			end
			S_MOD_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_MOD;
			end
			S_PULSE: begin
				cmd.pulse_calc = 1'b1;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
			end
			S_INST_GO: begin
				cmd.div_sel     = DIV_INST;
				cmd.inst_direct = sts.inst_direct;
				cmd.div_start   = !sts.inst_direct;
			end
			S_INST_WAIT: begin
				cmd.inst_take = sts.div_done;
			end
			S_SUM: begin
				cmd.sum_upd = 1'b1;
			end
			S_AVG_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_AVG;
			end
			S_OUT: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	`ASSERT_NEXT(a_accept_fetch, clk, arst_n, cmd.in_load, state_q == S_FETCH,
		"accepted item did not advance to fetch")

endmodule

`default_nettype wire

[rtl/wre_dp.sv]
// Datapath: snapshot ring, pulse and span arithmetic, running sum, output register.
// Depends on wre_pkg, wre_div and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module wre_dp #(
	parameter int WINDOW_DEPTH = 10
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire wre_pkg::ctrl_cmd_t            cmd,
	output wre_pkg::ctrl_sts_t                 sts,
	input  wire logic [wre_pkg::SCALE_W-1:0]   rate_scale,
	input  wire logic [wre_pkg::MOD_W-1:0]     counter_modulus,
	input  wire logic [wre_pkg::TIME_W-1:0]    time_us,
	input  wire logic [wre_pkg::COUNT_W-1:0]   pulse_count,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [wre_pkg::RATE_W-1:0]         rpm_average,
	output logic [wre_pkg::RATE_W-1:0]         rpm_instant
);
	import wre_pkg::*;

	localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W  = RATE_W + CNT_W;
	localparam int STEP_W = $clog2(SUM_W + 1);

	snap_t                 mem [WINDOW_DEPTH];
	snap_t                 rd_q;
	logic [WINDOW_DEPTH-1:0] valid_q;

	logic [SLOT_W-1:0]     slot_q;
	logic [CNT_W-1:0]      filled_q;
	logic [SUM_W-1:0]      sum_q;

	logic [TIME_W-1:0]     time_q;
	logic [COUNT_W-1:0]    count_q;
	logic [TIME_W-1:0]     elapsed_q;
	logic                  neg_q;
	logic [COUNT_W-1:0]    mag_q;
	logic [RATE_W-1:0]     old_rate_q;
	logic [COUNT_W-1:0]    pulses_q;
	logic [PROD_W-1:0]     prod_q;
	logic [RATE_W-1:0]     inst_q;

	logic                  out_valid_q;
	logic [RATE_W-1:0]     avg_q;
	logic [RATE_W-1:0]     inst_out_q;

	snap_t                 old_snap;
	logic [DIFF_W-1:0]     diff;
	logic [DIFF_W-1:0]     diff_abs;
	logic [MOD_W-1:0]      mod_eff;
	logic [COUNT_W-1:0]    rem_small;
	logic                  span_zero;
	logic                  rate_sat;

	logic [REM_W-1:0]      div_rem_init;
	logic [SUM_W-1:0]      div_num;
	logic [REM_W-1:0]      div_den;
	logic [STEP_W-1:0]     div_steps;
	logic                  div_busy;
	logic                  div_done;
	logic [SUM_W-1:0]      div_quo;
	logic [REM_W-1:0]      div_rem;

	always_comb begin
		old_snap  = valid_q[slot_q] ? rd_q : '0;
		diff      = {1'b0, count_q} - {1'b0, old_snap.pulse_count};
		diff_abs  = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
		mod_eff   = (counter_modulus == '0) ? MOD_W'(1) : counter_modulus;
		rem_small = div_rem[COUNT_W-1:0];
		span_zero = (elapsed_q == '0);
		rate_sat  = (REM_W'(prod_q[PROD_W-1:RATE_W]) >= elapsed_q);
	end

	always_comb begin
		div_rem_init = '0;
		div_num      = '0;
		div_den      = REM_W'(1);
		div_steps    = STEP_W'(SUM_W);
		unique case (cmd.div_sel)
			DIV_MOD: begin
				div_num   = {mag_q, {(SUM_W - COUNT_W){1'b0}}};
				div_den   = REM_W'(mod_eff);
				div_steps = STEP_W'(COUNT_W);
			end
			DIV_INST: begin
				div_rem_init = REM_W'(prod_q[PROD_W-1:RATE_W]);
				div_num      = {prod_q[RATE_W-1:0], {(SUM_W - RATE_W){1'b0}}};
				div_den      = elapsed_q;
				div_steps    = STEP_W'(RATE_W);
			end
			DIV_AVG: begin
				div_num   = sum_q;
				div_den   = REM_W'(filled_q);
				div_steps = STEP_W'(SUM_W);
			end
			default: begin
				div_num = '0;
			end
		endcase
	end

	wre_div #(
		.NUM_W(SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.rem_init (div_rem_init),
		.num      (div_num),
		.den      (div_den),
		.steps    (div_steps),
		.busy     (div_busy),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.sum_upd) begin
			mem[slot_q] <= '{time_us: time_q, pulse_count: count_q, rate: inst_q};
		end
		rd_q <= mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			slot_q   <= '0;
			filled_q <= '0;
			sum_q    <= '0;
		end else if (cmd.sum_upd) begin
			valid_q[slot_q] <= 1'b1;
			slot_q          <= (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0
				: slot_q + SLOT_W'(1);
			if (filled_q < CNT_W'(WINDOW_DEPTH)) begin
				filled_q <= filled_q + CNT_W'(1);
			end
			sum_q <= sum_q - SUM_W'(old_rate_q) + SUM_W'(inst_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			time_q  <= time_us;
			count_q <= pulse_count;
		end
		if (cmd.fetch) begin
			elapsed_q  <= time_q - old_snap.time_us;
			neg_q      <= diff[DIFF_W-1];
			mag_q      <= diff_abs[COUNT_W-1:0];
			old_rate_q <= old_snap.rate;
		end
		if (cmd.pulse_calc) begin
			pulses_q <= (neg_q && rem_small != '0) ? (mod_eff - rem_small) : rem_small;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(rate_scale) * PROD_W'(pulses_q);
		end
		if (cmd.inst_direct) begin
			inst_q <= span_zero ? '0 : RATE_MAX;
		end else if (cmd.inst_take) begin
			inst_q <= div_quo[RATE_W-1:0];
		end
		if (cmd.out_load) begin
			avg_q      <= (div_quo[SUM_W-1:RATE_W] != '0) ? RATE_MAX : div_quo[RATE_W-1:0];
			inst_out_q <= inst_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.div_done    = div_done;
		sts.inst_direct = span_zero || rate_sat;
		sts.out_free    = !out_valid_q || out_ready;
	end

	assign out_valid   = out_valid_q;
	assign rpm_average = avg_q;
	assign rpm_instant = inst_out_q;

	`ASSERT_ALWAYS(a_filled_bound, clk, arst_n, filled_q <= CNT_W'(WINDOW_DEPTH),
		"filled slot count exceeds window")
	`ASSERT_IMPLIES(a_sum_no_underflow, clk, arst_n, cmd.sum_upd,
		sum_q >= SUM_W'(old_rate_q), "running sum lacks the oldest rate")
	`ASSERT_IMPLIES(a_out_no_overwrite, clk, arst_n, cmd.out_load,
		!out_valid_q || out_ready, "pending result overwritten")
	`ASSERT_IMPLIES(a_div_idle_on_start, clk, arst_n, cmd.div_start, !div_busy,
		"divide requested while divider busy")

endmodule

`default_nettype wire

[rtl/windowed_rpm_estimator.sv]
// Windowed RPM estimator top level: config registers, controller and datapath.
// Each item runs the count modulo, the rate quotient and the average in turn on the
// shared bit-serial divider; the rate divide is skipped when the time span is zero
// or the rate saturates. SUM_W = 16 + clog2(depth + 1). A new item is accepted only
// once the previous result has been loaded into the output register.
// Reset: asynchronous, clears the ring valid flags, sum and counters and loads register defaults.
`default_nettype none

module windowed_rpm_estimator #(
	parameter int WINDOW_DEPTH = 10
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// [31:0] time_us, [46:32] pulse_count, [47] zero
	input  wire logic [wre_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// [15:0] rpm_average, [31:16] rpm_instant
	output logic [wre_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [wre_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [wre_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import wre_pkg::*;

	logic [SCALE_W-1:0] scale_q;
	logic [MOD_W-1:0]   modulus_q;
	ctrl_cmd_t          cmd;
	ctrl_sts_t          sts;
	logic [RATE_W-1:0]  rpm_average;
	logic [RATE_W-1:0]  rpm_instant;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q   <= SCALE_RESET;
			modulus_q <= MODULUS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RATE_SCALE: begin
					scale_q <= cfg_data[SCALE_W-1:0];
				end
				REG_COUNTER_MODULUS: begin
					modulus_q <= cfg_data[MOD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	wre_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wre_dp #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.rate_scale      (scale_q),
		.counter_modulus (modulus_q),
		.time_us         (s_axis_tdata[TIME_W-1:0]),
		.pulse_count     (s_axis_tdata[TIME_W+COUNT_W-1:TIME_W]),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.rpm_average     (rpm_average),
		.rpm_instant     (rpm_instant)
	);

	assign m_axis_tdata = {rpm_instant, rpm_average};

endmodule

`default_nettype wire

[sim/windowed_rpm_estimator_tb.sv]
// Self-checking testbench for windowed_rpm_estimator: a cycle-free window predictor
// runs beside the block and each output item is checked against it.
// Depends on wre_pkg and the windowed_rpm_estimator RTL only.
`timescale 1ns / 1ps

module windowed_rpm_estimator_tb;
	import wre_pkg::*;

	localparam int DEPTH       = 10;
	localparam int STALL_LIMIT = 5000;
	localparam int LONG_HOLD   = 600;
	localparam int SWEEP_ITEMS = 150;

	typedef struct {
		logic [RATE_W-1:0] average;
		logic [RATE_W-1:0] instant;
	} rpm_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor state
	logic [TIME_W-1:0]  ring_time [DEPTH];
	logic [COUNT_W-1:0] ring_count [DEPTH];
	logic [RATE_W-1:0]  ring_rate [DEPTH];
	int unsigned        next_slot;
	int unsigned        used_slots;
	int unsigned        rate_total;
	logic [SCALE_W-1:0] cur_scale;
	logic [MOD_W-1:0]   cur_modulus;

	rpm_result_t        rpm_expected [$];
	int                 error_count = 0;
	int                 idle_cycles = 0;
	int                 hold_request = 0;
	bit                 src_idle_en = 1'b0;
	bit                 sink_idle_en = 1'b0;
	logic [TIME_W-1:0]  seq_time = '0;
	logic [COUNT_W-1:0] seq_count = '0;

	windowed_rpm_estimator #(
		.WINDOW_DEPTH(DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	function void clear_window();
		for (int i = 0; i < DEPTH; i++) begin
			ring_time[i] = '0;
			ring_count[i] = '0;
			ring_rate[i] = '0;
		end
		next_slot = 0;
		used_slots = 0;
		rate_total = 0;
		cur_scale = SCALE_RESET;
		cur_modulus = MODULUS_RESET;
	endfunction

	function void predict_window(input logic [TIME_W-1:0] t_now,
			input logic [COUNT_W-1:0] cnt, output rpm_result_t res);
		int unsigned       slot;
		longint            m;
		longint            r;
		logic [TIME_W-1:0] span;
		longint unsigned   q;
		logic [RATE_W-1:0] inst;
		int unsigned       avg;
		slot = next_slot;
		m = (cur_modulus == 0) ? 64'sd1 : longint'(cur_modulus);
		r = (m + longint'(cnt) - longint'(ring_count[slot])) % m;
		if (r < 0)
			r += m;
		span = t_now - ring_time[slot];
		inst = '0;
		if (span != 0) begin
			q = (longint'(cur_scale) * longint'(r)) / longint'(span);
			inst = (q > 64'd65535) ? RATE_MAX : q[RATE_W-1:0];
		end
		rate_total = rate_total - ring_rate[slot] + inst;
		ring_time[slot] = t_now;
		ring_count[slot] = cnt;
		ring_rate[slot] = inst;
		next_slot = (slot + 1) % DEPTH;
		if (used_slots < DEPTH)
			used_slots++;
		avg = rate_total / used_slots;
		res.average = (avg > 65535) ? RATE_MAX : avg[RATE_W-1:0];
		res.instant = inst;
	endfunction

	task automatic send_sample(input logic [TIME_W-1:0] t_now, input logic [COUNT_W-1:0] cnt);
		rpm_result_t res;
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, cnt, t_now};
		do @(posedge clk); while (!s_axis_tready);
		predict_window(t_now, cnt, res);
		rpm_expected = {rpm_expected, res};
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (rpm_expected.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_RATE_SCALE)
			cur_scale = val[SCALE_W-1:0];
		else if (idx == REG_COUNTER_MODULUS)
			cur_modulus = val[MOD_W-1:0];
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_stream_sample();
		int unsigned        sel;
		logic [TIME_W-1:0]  t_now;
		logic [COUNT_W-1:0] cnt;
		sel = $urandom_range(0, 15);
		if (sel == 0 || cur_modulus < 2) begin
			t_now = $urandom;
			cnt = COUNT_W'($urandom_range(0, 32767));
		end else begin
			if (sel == 1)
				seq_time += $urandom_range(0, 300);
			else if (sel == 2)
				seq_time += $urandom;
			else
				seq_time += $urandom_range(20000, 200000);
			seq_count = COUNT_W'((int'(seq_count) + $urandom_range(0, 500)) % int'(cur_modulus));
			t_now = seq_time;
			cnt = seq_count;
		end
		send_sample(t_now, cnt);
	endtask

	task automatic test_startup_window();
		send_sample(32'd0, 15'd0);
		for (int i = 1; i < 6; i++)
			send_sample(TIME_W'(i * 100000), COUNT_W'(i * 40));
		drain();
	endtask

	task automatic test_corner_cases();
		write_reg(REG_RATE_SCALE, 24'hFFFFFF);
		send_sample(32'd700001, 15'd32766);
		send_sample(32'hFFFF_FFFF, 15'd0);
		send_sample(32'h0000_0010, 15'd10);
		write_reg(REG_COUNTER_MODULUS, 24'd100);
		send_sample(32'd900000, 15'h7FFF);
		send_sample(32'd1000000, 15'd0);
		send_sample(ring_time[next_slot], 15'd5);
		write_reg(REG_COUNTER_MODULUS, 24'd0);
		send_sample(32'd1200000, 15'd77);
		write_reg(REG_COUNTER_MODULUS, 24'd1);
		send_sample(32'd1300000, 15'd1234);
		write_reg(REG_RATE_SCALE, 24'd0);
		send_sample(32'd1400000, 15'd300);
		write_reg(CFG_IDX_W'($urandom_range(2, 255)), 24'h5A5A5A);
		send_sample(32'd1500000, 15'd400);
		write_reg(REG_RATE_SCALE, SCALE_RESET);
		write_reg(REG_COUNTER_MODULUS, CFG_DATA_W'(MODULUS_RESET));
		send_sample(32'd1600000, 15'd500);
		drain();
	endtask

	task automatic test_config_sweep();
		logic [CFG_DATA_W-1:0] scale_val;
		logic [CFG_DATA_W-1:0] mod_val;
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: begin
					scale_val = 24'd1;
					mod_val = 24'd2;
				end
				1: begin
					scale_val = 24'hFFFFFF;
					mod_val = 24'd32767;
				end
				2: begin
					scale_val = 24'd15000000;
					mod_val = 24'd60;
				end
				3: begin
					scale_val = 24'd7500000;
					mod_val = 24'd32767;
				end
				default: begin
					scale_val = CFG_DATA_W'($urandom_range(1, 24'hFFFFFF));
					mod_val = CFG_DATA_W'($urandom_range(2, 32767));
				end
			endcase
			write_reg(REG_RATE_SCALE, scale_val);
			write_reg(REG_COUNTER_MODULUS, mod_val);
			if (phase == 6)
				write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
			seq_count = COUNT_W'(int'(seq_count) % int'(cur_modulus));
			src_idle_en = $urandom_range(0, 2) != 0;
			sink_idle_en = $urandom_range(0, 2) != 0;
			repeat (SWEEP_ITEMS) send_stream_sample();
			drain();
		end
	endtask

	task automatic test_output_stall();
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		hold_request = LONG_HOLD;
		repeat (30) send_stream_sample();
		drain();
	endtask

	task automatic test_full_rate();
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		repeat (270) send_stream_sample();
		drain();
	endtask

	initial begin
		int hold;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				m_axis_tready <= 1'b0;
			end else if (hold_request > 0) begin
				hold = hold_request;
				hold_request = 0;
				m_axis_tready <= 1'b0;
				repeat (hold) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		rpm_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (rpm_expected.size() == 0) begin
				$error("unexpected item: rpm_average %0d rpm_instant %0d",
					m_axis_tdata[15:0], m_axis_tdata[31:16]);
				error_count++;
			end else begin
				want = rpm_expected.pop_front();
				if (m_axis_tdata[15:0] !== want.average) begin
					$error("rpm_average mismatch: expected %0d, got %0d",
						want.average, m_axis_tdata[15:0]);
					error_count++;
				end
				if (m_axis_tdata[31:16] !== want.instant) begin
					$error("rpm_instant mismatch: expected %0d, got %0d",
						want.instant, m_axis_tdata[31:16]);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		clear_window();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_startup_window();
		test_corner_cases();
		test_config_sweep();
		test_output_stall();
		test_full_rate();
		drain();
		repeat (80) @(posedge clk);
		if (error_count == 0 && rpm_expected.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
